@@ src/tfr_pkg.sv @@
// shared types and constants of the token frame reassembler
`default_nettype none
package tfr_pkg;

  // default configuration
  localparam int unsigned DEF_MAX_TOKENS    = 32;
  localparam int unsigned DEF_PAYLOAD_BYTES = 32;
  localparam int unsigned DEF_TOKEN_CHARS   = 29;

  // payload header positions
  localparam logic [4:0] POS_INDEX = 5'd0;
  localparam logic [4:0] POS_TOTAL = 5'd1;
  localparam logic [4:0] POS_FRAME = 5'd2;
  localparam logic [4:0] POS_TEXT  = 5'd3;

  // input beat kind
  localparam logic MODE_PAYLOAD = 1'b0;
  localparam logic MODE_READ    = 1'b1;

  // result beat kind
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_TOTAL = 2'd1,
    STAT_BAD_INDEX = 2'd2
  } status_e;

  typedef struct packed {
    logic       mode;
    logic       first_byte;
    logic [7:0] payload_byte;
    logic [4:0] read_token;
    logic [4:0] read_char;
  } item_t;

  // result fields handed from the control path to the output stages
  typedef struct packed {
    logic       kind;
    status_e    status;
    logic       done;
    logic [7:0] index;
    logic [5:0] count;
    logic [5:0] total;
    logic       hit;
  } res_t;

endpackage
`default_nettype wire

@@ src/tfr_in_if.sv @@
// input channel of the token frame reassembler
`default_nettype none
interface tfr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic       first_byte;
  logic [7:0] payload_byte;
  logic [4:0] read_token;
  logic [4:0] read_char;

  modport source (
    output valid, mode, first_byte, payload_byte, read_token, read_char,
    input  ready
  );
  modport sink (
    input  valid, mode, first_byte, payload_byte, read_token, read_char,
    output ready
  );
endinterface
`default_nettype wire

@@ src/tfr_out_if.sv @@
// result channel of the token frame reassembler
`default_nettype none
interface tfr_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [1:0] status;
  logic       frame_complete;
  logic [7:0] token_index;
  logic [5:0] received_count;
  logic [5:0] frame_total;
  logic [7:0] read_value;

  modport source (
    output valid, result_kind, status, frame_complete, token_index,
           received_count, frame_total, read_value,
    input  ready
  );
  modport sink (
    input  valid, result_kind, status, frame_complete, token_index,
           received_count, frame_total, read_value,
    output ready
  );
endinterface
`default_nettype wire

@@ src/token_frame_reassembler.sv @@
// token frame reassembler top level
// a result beat is registered in the result stage and then in the output register before it is valid
// throughput: one input beat per cycle; input stalls only while the result stage and the
//   output register both hold a beat and the output side is not ready
// payload bytes other than the last give no result beat; one text store access a cycle
// reset clears position, frame state and bitmap; stored text is read only behind a set bit
`default_nettype none
module token_frame_reassembler
  import tfr_pkg::*;
#(
  parameter int unsigned MAX_TOKENS    = DEF_MAX_TOKENS,
  parameter int unsigned PAYLOAD_BYTES = DEF_PAYLOAD_BYTES,
  parameter int unsigned TOKEN_CHARS   = DEF_TOKEN_CHARS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tfr_in_if.sink    in_i,
  tfr_out_if.source out_o
);

  localparam int unsigned DEPTH = MAX_TOKENS * TOKEN_CHARS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t         item;
  logic          accept;
  logic          ready;
  logic          res_valid;
  res_t          res;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  res_t          out_res;
  logic [7:0]    out_value;

  // pack the input beat
  assign item.mode         = in_i.mode;
  assign item.first_byte   = in_i.first_byte;
  assign item.payload_byte = in_i.payload_byte;
  assign item.read_token   = in_i.read_token;
  assign item.read_char    = in_i.read_char;

  assign accept     = in_i.valid && ready;
  assign in_i.ready = ready;

  // header parsing, bitmap and count, store addressing
  tfr_ctrl #(
    .MAX_TOKENS   (MAX_TOKENS),
    .PAYLOAD_BYTES(PAYLOAD_BYTES),
    .TOKEN_CHARS  (TOKEN_CHARS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item),
    .res_valid_o(res_valid),
    .res_o      (res),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .re_o       (re),
    .raddr_o    (raddr)
  );

  // token text, one row of characters per token index
  tfr_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // result stage plus output register, so a stalled result does not block input
  tfr_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .res_valid_i(res_valid),
    .res_i      (res),
    .rdata_i    (rdata),
    .in_ready_o (ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .out_res_o  (out_res),
    .out_value_o(out_value)
  );

  assign out_o.result_kind    = out_res.kind;
  assign out_o.status         = out_res.status;
  assign out_o.frame_complete = out_res.done;
  assign out_o.token_index    = out_res.index;
  assign out_o.received_count = out_res.count;
  assign out_o.frame_total    = out_res.total;
  assign out_o.read_value     = out_value;

endmodule
`default_nettype wire

@@ src/tfr_ram.sv @@
// generic single write port ram with registered read
`default_nettype none
module tfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ src/tfr_ctrl.sv @@
// payload parsing, frame bitmap and text store addressing
`default_nettype none
module tfr_ctrl
  import tfr_pkg::*;
#(
  parameter int unsigned MAX_TOKENS    = DEF_MAX_TOKENS,
  parameter int unsigned PAYLOAD_BYTES = DEF_PAYLOAD_BYTES,
  parameter int unsigned TOKEN_CHARS   = DEF_TOKEN_CHARS,
  localparam int unsigned DEPTH = MAX_TOKENS * TOKEN_CHARS,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire item_t         item_i,
  output logic               res_valid_o,
  output res_t               res_o,
  output logic               we_o,
  output logic [AW-1:0]      waddr_o,
  output logic [7:0]         wdata_o,
  output logic               re_o,
  output logic [AW-1:0]      raddr_o
);

  localparam int unsigned TW         = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int unsigned CW         = $clog2(MAX_TOKENS + 1);
  localparam int unsigned TEXT_BYTES = PAYLOAD_BYTES - 3;
  localparam int unsigned READ_CHARS = (TOKEN_CHARS < TEXT_BYTES) ? TOKEN_CHARS : TEXT_BYTES;

  logic [4:0]            pos_q, pos_d;
  logic [7:0]            pidx_q, pidx_d;
  logic [7:0]            ptot_q, ptot_d;
  logic                  pok_q, pok_d;
  logic                  tend_q, tend_d;
  logic [CW-1:0]         ctot_q, ctot_d;
  logic [7:0]            cfrm_q, cfrm_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [MAX_TOKENS-1:0] bits_q, bits_d;

  logic          is_payload;
  logic [4:0]    pos;
  logic [4:0]    off;
  logic          last;
  status_e       st;
  logic [TW-1:0] ptok;
  logic [7:0]    rtok8;
  logic [TW-1:0] rtok;
  logic          rd_hit;
  logic [7:0]    ch;
  logic [7:0]    cnt8;
  logic [7:0]    tot8;

  assign is_payload = accept_i && (item_i.mode == MODE_PAYLOAD);
  assign ptok  = pidx_q[TW-1:0];
  assign rtok8 = 8'(item_i.read_token);
  assign rtok  = rtok8[TW-1:0];

  always_comb begin
    if (ptot_q == 8'd0 || ptot_q > 8'(MAX_TOKENS)) begin
      st = STAT_BAD_TOTAL;
    end else if (pidx_q >= ptot_q) begin
      st = STAT_BAD_INDEX;
    end else begin
      st = STAT_OK;
    end
  end

  // position of this byte within the payload
  always_comb begin
    pos = item_i.first_byte ? POS_INDEX : pos_q;
    if (6'(pos) >= 6'(PAYLOAD_BYTES)) begin
      pos = POS_INDEX;
    end
  end

  assign off  = pos - POS_TEXT;
  assign last = (6'(pos) + 6'd1) >= 6'(PAYLOAD_BYTES);
  assign ch   = (tend_q || item_i.payload_byte == 8'd0) ? 8'd0 : item_i.payload_byte;

  always_comb begin
    pos_d  = pos_q;
    pidx_d = pidx_q;
    ptot_d = ptot_q;
    pok_d  = pok_q;
    tend_d = tend_q;
    ctot_d = ctot_q;
    cfrm_d = cfrm_q;
    cnt_d  = cnt_q;
    bits_d = bits_q;
    we_o   = 1'b0;
    if (is_payload) begin
      case (pos)
        POS_INDEX: begin
          pidx_d = item_i.payload_byte;
          pok_d  = 1'b0;
        end
        POS_TOTAL: begin
          ptot_d = item_i.payload_byte;
        end
        POS_FRAME: begin
          pok_d  = (st == STAT_OK);
          tend_d = 1'b0;
          // new frame: drop what was gathered so far
          if (st == STAT_OK && (8'(ctot_q) != ptot_q || cfrm_q != item_i.payload_byte)) begin
            ctot_d = CW'(ptot_q);
            cfrm_d = item_i.payload_byte;
            cnt_d  = '0;
            bits_d = '0;
          end
        end
        default: begin
          if (ch == 8'd0) begin
            tend_d = 1'b1;
          end
          we_o = pok_q && (6'(off) < 6'(TOKEN_CHARS)) && (pidx_q < 8'(MAX_TOKENS));
        end
      endcase
      if (last) begin
        pos_d = POS_INDEX;
        if (pok_q && st == STAT_OK && pidx_q < 8'(MAX_TOKENS) && !bits_q[ptok]) begin
          bits_d[ptok] = 1'b1;
          cnt_d        = cnt_q + CW'(1);
        end
      end else begin
        pos_d = pos + 5'd1;
      end
    end
  end

  assign waddr_o = AW'(ptok) * AW'(TOKEN_CHARS) + AW'(off);
  assign wdata_o = ch;

  // read side
  assign rd_hit = (rtok8 < 8'(MAX_TOKENS)) && bits_q[rtok]
               && (6'(item_i.read_char) < 6'(READ_CHARS));
  assign re_o    = accept_i && (item_i.mode == MODE_READ) && rd_hit;
  assign raddr_o = AW'(rtok) * AW'(TOKEN_CHARS) + AW'(item_i.read_char);

  assign cnt8 = 8'(cnt_d);
  assign tot8 = 8'(ctot_d);

  always_comb begin
    res_valid_o = accept_i && ((item_i.mode == MODE_READ) || last);
    res_o.count = cnt8[5:0];
    res_o.total = tot8[5:0];
    if (item_i.mode == MODE_READ) begin
      res_o.kind   = KIND_READ;
      res_o.status = STAT_OK;
      res_o.done   = 1'b0;
      res_o.index  = 8'd0;
      res_o.hit    = rd_hit;
    end else begin
      res_o.kind   = KIND_STATUS;
      res_o.status = st;
      res_o.done   = pok_q && (st == STAT_OK) && (pidx_q < 8'(MAX_TOKENS))
                     && (cnt_d >= ctot_q);
      res_o.index  = pidx_q;
      res_o.hit    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      pidx_q <= '0;
      ptot_q <= '0;
      pok_q  <= 1'b0;
      tend_q <= 1'b0;
      ctot_q <= '0;
      cfrm_q <= '0;
      cnt_q  <= '0;
      bits_q <= '0;
    end else begin
      pos_q  <= pos_d;
      pidx_q <= pidx_d;
      ptot_q <= ptot_d;
      pok_q  <= pok_d;
      tend_q <= tend_d;
      ctot_q <= ctot_d;
      cfrm_q <= cfrm_d;
      cnt_q  <= cnt_d;
      bits_q <= bits_d;
    end
  end

endmodule
`default_nettype wire

@@ src/tfr_out.sv @@
// result stage and output register with backpressure
`default_nettype none
module tfr_out
  import tfr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic       res_valid_i,
  input  wire res_t       res_i,
  input  wire logic [7:0] rdata_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output res_t            out_res_o,
  output logic [7:0]      out_value_o
);

  logic       s1_valid_q;
  res_t       s1_q;
  logic       o_valid_q;
  res_t       o_q;
  logic [7:0] o_value_q;
  logic       s1_move;

  assign s1_move    = s1_valid_q && (!o_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      if (accept_i && res_valid_i) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        o_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  // ram read data lines up with the s1 stage
  always_ff @(posedge clk_i) begin
    if (accept_i && res_valid_i) begin
      s1_q <= res_i;
    end
    if (s1_move) begin
      o_q       <= s1_q;
      o_value_q <= s1_q.hit ? rdata_i : 8'd0;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_res_o   = o_q;
  assign out_value_o = o_value_q;

endmodule
`default_nettype wire
